[rtl/imu_dead_reckoning_estimator_macros.svh]
// Assertion helpers for the dead-reckoning estimator. Each one samples on clk
// and is switched off while rst is high.
`ifndef IMU_DEAD_RECKONING_ESTIMATOR_MACROS_SVH
`define IMU_DEAD_RECKONING_ESTIMATOR_MACROS_SVH

// Property holds in the same cycle.
`define IMU_DR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IMU_DR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/imu_dr_pkg.sv]
package imu_dr_pkg;

  localparam int COV_ENTRIES_DEF = 16;

  localparam int VAL_W   = 32;
  localparam int HDOP_W  = 16;
  localparam int TIME_W  = 32;
  localparam int TOUT_W  = 24;
  localparam int COV_W   = 40;
  localparam int NORM_W  = 64;
  localparam int CFG_IDX_W = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DIV_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 4'd1;

  // Item kinds.
  localparam logic MODE_IMU = 1'b0;
  localparam logic MODE_GPS = 1'b1;

  // Covariance entries loaded by a fix.
  localparam int COV_IDX_X = 0;
  localparam int COV_IDX_Y = 1;
  localparam int COV_IDX_Z = 2;

  // 0.02 s in Q0.16, 9.81 in Q16.16, 0.001 in Q0.24.
  localparam logic signed [11:0] DT_Q16      = 12'sd1311;
  localparam logic signed [33:0] GRAVITY_Q16 = 34'sd642908;
  localparam logic signed [45:0] DT_ROUND    = 46'sd32768;
  localparam logic [14:0]        GROWTH_Q24  = 15'd16777;
  localparam logic [54:0]        GROWTH_RND  = 55'd8388608;

  localparam logic [COV_W-1:0]  COV_MAX       = 40'hFF_FFFF_FFFF;
  localparam logic [TOUT_W-1:0] TIMEOUT_RESET = 24'd2000;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [34:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/imu_dr_if.sv]
// Input channel: one IMU sample or GPS fix per word.
interface imu_dr_sample_if import imu_dr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [VAL_W-1:0]  value_x;
  logic signed [VAL_W-1:0]  value_y;
  logic signed [VAL_W-1:0]  value_z;
  logic [HDOP_W-1:0]        hdop;
  logic [TIME_W-1:0]        timestamp_ms;

  modport source (output valid, mode, value_x, value_y, value_z, hdop, timestamp_ms,
                  input ready);
  modport sink   (input valid, mode, value_x, value_y, value_z, hdop, timestamp_ms,
                  output ready);
endinterface

// Result channel: the estimator state after one input word.
interface imu_dr_result_if import imu_dr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  pos_x;
  logic signed [VAL_W-1:0]  pos_y;
  logic signed [VAL_W-1:0]  pos_z;
  logic signed [VAL_W-1:0]  vel_x;
  logic signed [VAL_W-1:0]  vel_y;
  logic signed [VAL_W-1:0]  vel_z;
  logic                     dead_reckoning;
  logic                     diverged;
  logic [NORM_W-1:0]        norm_squared;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  dead_reckoning, diverged, norm_squared, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  dead_reckoning, diverged, norm_squared, output ready);
endinterface

// Configuration write channel.
interface imu_dr_cfg_if import imu_dr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [COV_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/imu_dead_reckoning_estimator.sv]
// Channel  | Port   | Direction | Word
// ---------+--------+-----------+--------------------------------------------------
// sample   | sample | in        | mode, value_x/y/z, hdop, timestamp_ms
// result   | result | out       | pos/vel x/y/z, dead_reckoning, diverged, norm_squared
// config   | cfg    | in        | index, data (0: divergence_limit, 1: timeout_ms)
//
// An IMU word runs the velocity and position steps before the walk over the
// covariance memory, while a GPS word goes straight to the walk; the walk reads
// one entry a cycle through a single read port and a four-stage update and
// squaring pipe.
// Reset (rst, synchronous) clears the kinematic state, the fix bookkeeping, the
// covariance valid bits and the result channel; no clearing pass is needed.
// A new sample is taken while an earlier result still waits in the output
// register; the block stalls only when a finished result meets a full register.
// Configuration words are always accepted and must only arrive while idle.
module imu_dead_reckoning_estimator import imu_dr_pkg::*; #(
  parameter int COV_ENTRIES = COV_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  imu_dr_sample_if.sink     sample,
  imu_dr_result_if.source   result,
  imu_dr_cfg_if.sink        cfg
);

`include "imu_dead_reckoning_estimator_macros.svh"

  localparam int AW = $clog2(COV_ENTRIES);
  localparam int CW = $clog2(COV_ENTRIES + 1);
  localparam logic [CW-1:0] LIM_SLOT = CW'(COV_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_KIN, S_VEL, S_POS, S_WALK, S_DRAIN, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [COV_W-1:0]  div_limit;
  logic [TOUT_W-1:0] timeout;

  // Captured sample word.
  logic                    in_mode;
  logic signed [VAL_W-1:0] in_val [3];
  logic [HDOP_W-1:0]       in_hdop;
  logic [TIME_W-1:0]       in_time;

  // Kinematic and fix state.
  logic signed [VAL_W-1:0] vel [3];
  logic signed [VAL_W-1:0] pos [3];
  logic [TIME_W-1:0]       last_fix;
  logic                    fix_seen;
  logic                    dr_active;
  logic [1:0]              axis;
  logic [34:0]             gps_var;

  // Covariance memory with one valid bit per entry; an entry never written
  // reads as zero.
  logic [COV_W-1:0]       cov_mem [COV_ENTRIES];
  logic [COV_ENTRIES-1:0] cov_vld;
  logic [COV_W-1:0]       rd_data;
  logic                   rd_ok;
  logic [CW-1:0]          cnt;

  // Walk pipeline: A holds read data, B the updated value, C the partial
  // squares, D the assembled square.
  logic              a_vld, b_vld, c_vld, d_vld;
  logic [CW-1:0]     a_idx;
  logic              b_lim, c_lim, d_lim;
  logic [COV_W-1:0]  sq_c;
  logic [39:0]       hh, hl, ll;
  logic [NORM_W-1:0] term;
  logic [NORM_W-1:0] norm;
  logic [NORM_W-1:0] lim_sq;

  // Shared multiplier for the velocity and position steps.
  logic signed [33:0]      mul_a;
  logic signed [VAL_W-1:0] step_base;
  logic signed [45:0]      step_prod;
  logic signed [45:0]      step_rnd;
  logic signed [34:0]      step_sum;

  always_comb begin
    if (state == S_VEL) begin
      mul_a     = 34'(in_val[axis]) - ((axis == 2'(COV_IDX_Z)) ? GRAVITY_Q16 : 34'sd0);
      step_base = vel[axis];
    end else begin
      mul_a     = 34'(vel[axis]);
      step_base = pos[axis];
    end
    step_prod = 46'(mul_a) * 46'(DT_Q16);
    step_rnd  = step_prod + DT_ROUND;
    step_sum  = 35'(step_base) + 35'($signed(step_rnd[45:16]));
  end

  // Stage A: new covariance value for the entry just read.
  logic [COV_W-1:0] c_cur;
  logic [54:0]      grow_prod;
  logic [30:0]      grow_inc;
  logic [40:0]      grow_sum;
  logic [COV_W-1:0] grown;
  logic [COV_W-1:0] c_new;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;

  always_comb begin
    c_cur     = rd_ok ? rd_data : '0;
    grow_prod = 55'(c_cur) * 55'(GROWTH_Q24);
    grow_inc  = 31'((grow_prod + GROWTH_RND) >> 24);
    grow_sum  = 41'(c_cur) + 41'(grow_inc);
    grown     = (grow_sum > 41'(COV_MAX)) ? COV_MAX : grow_sum[COV_W-1:0];
    if (a_idx == LIM_SLOT) begin
      c_new = div_limit;
    end else if (in_mode == MODE_GPS &&
                 (a_idx == CW'(COV_IDX_X) || a_idx == CW'(COV_IDX_Y))) begin
      c_new = 40'(gps_var);
    end else if (in_mode == MODE_GPS && a_idx == CW'(COV_IDX_Z)) begin
      c_new = 40'(gps_var) << 1;
    end else if (dr_active) begin
      c_new = grown;
    end else begin
      c_new = c_cur;
    end
    mem_we  = a_vld && (a_idx != LIM_SLOT);
    wr_addr = a_idx[AW-1:0];
  end

  // Stage D input: floor(c^2 / 2^16) from the three partial products.
  logic [NORM_W-1:0] term_next;
  logic [NORM_W:0]   acc_sum;

  always_comb begin
    term_next = (64'(hh) << 24) + (64'(hl) << 5) + 64'(ll >> 16);
    acc_sum   = 65'(norm) + 65'(term);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cov_mem[wr_addr] <= c_new;
    end
    rd_data <= cov_mem[cnt[AW-1:0]];
  end

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_limit    <= COV_MAX;
      timeout      <= TIMEOUT_RESET;
      vel          <= '{default: '0};
      pos          <= '{default: '0};
      last_fix     <= '0;
      fix_seen     <= 1'b0;
      dr_active    <= 1'b0;
      cov_vld      <= '0;
      a_vld        <= 1'b0;
      b_vld        <= 1'b0;
      c_vld        <= 1'b0;
      d_vld        <= 1'b0;
      axis         <= '0;
      cnt          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DIV_LIMIT: div_limit <= cfg.data;
          REG_TIMEOUT:   timeout   <= cfg.data[TOUT_W-1:0];
          default: ;
        endcase
      end

      // The completion state reloads the result register itself.
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end

      // Walk pipeline, advancing every cycle.
      a_vld <= (state == S_WALK);
      a_idx <= cnt;
      rd_ok <= cov_vld[cnt[AW-1:0]];
      b_vld <= a_vld;
      b_lim <= (a_idx == LIM_SLOT);
      sq_c  <= c_new;
      if (mem_we) begin
        cov_vld[wr_addr] <= 1'b1;
      end
      c_vld <= b_vld;
      c_lim <= b_lim;
      hh    <= 40'(sq_c[39:20]) * 40'(sq_c[39:20]);
      hl    <= 40'(sq_c[39:20]) * 40'(sq_c[19:0]);
      ll    <= 40'(sq_c[19:0]) * 40'(sq_c[19:0]);
      d_vld <= c_vld;
      d_lim <= c_lim;
      term  <= term_next;
      if (d_vld) begin
        if (d_lim) begin
          lim_sq <= term;
        end else begin
          norm <= acc_sum[NORM_W] ? '1 : acc_sum[NORM_W-1:0];
        end
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            in_mode   <= sample.mode;
            in_val[0] <= sample.value_x;
            in_val[1] <= sample.value_y;
            in_val[2] <= sample.value_z;
            in_hdop   <= sample.hdop;
            in_time   <= sample.timestamp_ms;
            state     <= S_KIN;
          end
        end
        S_KIN: begin
          norm <= '0;
          cnt  <= '0;
          axis <= '0;
          if (in_mode == MODE_GPS) begin
            last_fix  <= in_time;
            fix_seen  <= 1'b1;
            dr_active <= 1'b0;
            pos       <= in_val;
            gps_var   <= 35'({32'(in_hdop) * 32'(in_hdop), 2'b00});
            state     <= S_WALK;
          end else begin
            if (fix_seen) begin
              dr_active <= (in_time - last_fix) > 32'(timeout);
            end
            state <= S_VEL;
          end
        end
        S_VEL: begin
          vel[axis] <= sat32(step_sum);
          if (axis == 2'(COV_IDX_Z)) begin
            axis  <= '0;
            state <= S_POS;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_POS: begin
          pos[axis] <= sat32(step_sum);
          if (axis == 2'(COV_IDX_Z)) begin
            state <= S_WALK;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_WALK: begin
          // The slot after the last entry carries the divergence limit through
          // the squaring pipe.
          if (cnt == LIM_SLOT) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DRAIN: begin
          if (d_vld && d_lim) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.pos_x          <= pos[0];
            result.pos_y          <= pos[1];
            result.pos_z          <= pos[2];
            result.vel_x          <= vel[0];
            result.vel_y          <= vel[1];
            result.vel_z          <= vel[2];
            result.dead_reckoning <= dr_active;
            result.diverged       <= (norm > lim_sq);
            result.norm_squared   <= norm;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IMU_DR_ASSERT(a_mem_write_in_walk, !mem_we || state == S_WALK || state == S_DRAIN, "covariance written outside the walk")
  `IMU_DR_ASSERT(a_pipe_empty_done, state != S_DONE || !(a_vld || b_vld || c_vld || d_vld), "walk pipeline busy when the result is formed")
  `IMU_DR_ASSERT_NEXT(a_fix_clears_dr, state == S_KIN && in_mode == MODE_GPS, !dr_active && fix_seen, "fix left dead reckoning set")
  `IMU_DR_ASSERT_NEXT(a_result_from_done, !result.valid, !result.valid || $past(state) == S_DONE, "result raised outside completion")

endmodule
